// ----- rtl/running_mean_stdev_minmax_top_macros.svh -----
`ifndef RUNNING_MEAN_STDEV_MINMAX_TOP_MACROS_SVH
`define RUNNING_MEAN_STDEV_MINMAX_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RMSM_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RMSM_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rmsm_pkg.sv -----
`default_nettype none

package rmsm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 16;
    localparam int MEAN_W     = 32;
    localparam int MEAN_FRAC  = 16;
    localparam int M2_FRAC    = 12;
    localparam int PROD_SHIFT = 2 * MEAN_FRAC - M2_FRAC;
    localparam int DIFF_W     = MEAN_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int M2_W       = 64;
    localparam int ROOT_W     = M2_W / 2;
    localparam int SD_W       = 24;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam logic [COUNT_W-1:0]  COUNT_FULL = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel;      // 0: mean step, 1: variance step
        logic mean_upd;
        logic mul_start;
        logic m2_acc;
        logic sqrt_start;
        logic sd_zero;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic upd;
        logic div_done;
        logic mul_done;
        logic sqrt_done;
        logic count_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/rmsm_div.sv -----
`default_nettype none

module rmsm_div
    import rmsm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [M2_W-1:0]     dividend,
    input  wire logic [COUNT_W-1:0]  divisor,
    output logic      [M2_W-1:0]     quotient,
    output logic                     done
);

    localparam int CNT_W = $clog2(M2_W);

    logic [M2_W-1:0]    quot_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   rem_sh;
    logic               ge;
    logic [COUNT_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, quot_reg[M2_W-1]};
    assign ge      = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(M2_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[M2_W-2:0], ge};
            rem_reg  <= ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ----- rtl/rmsm_sqrt.sv -----
`default_nettype none

module rmsm_sqrt
    import rmsm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [M2_W-1:0]   radicand,
    output logic      [ROOT_W-1:0] root,
    output logic                   done
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    logic [M2_W-1:0]   val_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    assign rem_sh = {rem_reg[REM_W-3:0], val_reg[M2_W-1:M2_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // two radicand bits in, one root bit out per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[M2_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/rmsm_ctrl.sv -----
`default_nettype none

module rmsm_ctrl
    import rmsm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_CHK  = 12'b0000_0000_0010,
        S_DIV1 = 12'b0000_0000_0100,
        S_MEAN = 12'b0000_0000_1000,
        S_MULS = 12'b0000_0001_0000,
        S_MUL  = 12'b0000_0010_0000,
        S_ACC  = 12'b0000_0100_0000,
        S_STD  = 12'b0000_1000_0000,
        S_DIV2 = 12'b0001_0000_0000,
        S_SQS  = 12'b0010_0000_0000,
        S_SQW  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (st.upd)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV1;
                end
                else
                    state_next = S_STD;
            end
            S_DIV1:
                if (st.div_done)
                    state_next = S_MEAN;
            S_MEAN:
            begin
                cmd.mean_upd = 1'b1;
                state_next   = S_MULS;
            end
            S_MULS:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
                if (st.mul_done)
                    state_next = S_ACC;
            S_ACC:
            begin
                cmd.m2_acc = 1'b1;
                state_next = S_STD;
            end
            S_STD:
            begin
                if (st.count_zero)
                begin
                    cmd.sd_zero = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b1;
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                cmd.div_sel = 1'b1;
                if (st.div_done)
                    state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQW;
            end
            S_SQW:
                if (st.sqrt_done)
                    state_next = S_DONE;
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/rmsm_dp.sv -----
`default_nettype none

module rmsm_dp
    import rmsm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output status_t                  st,
    input  wire logic                req_type,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COUNT_W-1:0]       count_out,
    output logic [MEAN_W-1:0]        mean_out,
    output logic [SD_W-1:0]          stdev_out,
    output logic [SAMPLE_W-1:0]      min_out,
    output logic [SAMPLE_W-1:0]      max_out,
    output logic                     saturated_out
);

    localparam int MCNT_W = $clog2(DIFF_W);
    localparam int TERM_W = PROD_W - PROD_SHIFT;

    logic [COUNT_W-1:0]         count_reg;
    logic signed [MEAN_W-1:0]   mean_reg;
    logic [M2_W-1:0]            m2_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic                       full_reg;
    logic                       upd_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [DIFF_W-1:0]   d1_reg;
    logic [SD_W-1:0]            sd_reg;
    logic [PROD_W-1:0]          p_reg;
    logic [MCNT_W-1:0]          mcnt_reg;
    logic                       mbusy_reg;
    logic                       mdone_reg;
    logic                       out_valid_reg;

    logic signed [SAMPLE_W-1:0] x_in;
    logic signed [DIFF_W-1:0]   xs_in;
    logic signed [DIFF_W-1:0]   xs_cur;
    logic signed [DIFF_W-1:0]   mean_ext;
    logic signed [DIFF_W-1:0]   d1_in;
    logic signed [DIFF_W-1:0]   d2;
    logic [DIFF_W-1:0]          d1_mag;
    logic [DIFF_W-1:0]          d2_mag;
    logic [DIFF_W:0]            mul_sum;
    logic signed [DIFF_W:0]     delta;
    logic signed [DIFF_W:0]     mean_sum;
    logic [M2_W:0]              m2_sum;
    logic [M2_W-1:0]            div_a;
    logic [M2_W-1:0]            div_q;
    logic                       div_done;
    logic [M2_W-1:0]            radicand;
    logic [ROOT_W-1:0]          root;
    logic                       sqrt_done;

    assign x_in     = sample;
    assign xs_in    = {x_in[SAMPLE_W-1], x_in, {MEAN_FRAC{1'b0}}};
    assign xs_cur   = {x_reg[SAMPLE_W-1], x_reg, {MEAN_FRAC{1'b0}}};
    assign mean_ext = {mean_reg[MEAN_W-1], mean_reg};
    assign d1_in    = xs_in - mean_ext;
    assign d2       = xs_cur - mean_ext;
    assign d1_mag   = d1_reg[DIFF_W-1] ? DIFF_W'(-d1_reg) : DIFF_W'(d1_reg);
    assign d2_mag   = d2[DIFF_W-1] ? DIFF_W'(-d2) : DIFF_W'(d2);

    // truncating signed step: apply the sign of d1 to the magnitude quotient
    assign delta    = d1_reg[DIFF_W-1] ? -$signed({1'b0, div_q[DIFF_W-1:0]})
                                       : $signed({1'b0, div_q[DIFF_W-1:0]});
    assign mean_sum = {mean_ext[DIFF_W-1], mean_ext} + delta;

    assign mul_sum  = {1'b0, p_reg[PROD_W-1:DIFF_W]} + (p_reg[0] ? {1'b0, d1_mag} : '0);
    assign m2_sum   = {1'b0, m2_reg} + {1'b0, {(M2_W-TERM_W){1'b0}},
                                        p_reg[PROD_W-1:PROD_SHIFT]};

    assign div_a    = cmd.div_sel ? m2_reg : {{(M2_W-DIFF_W){1'b0}}, d1_mag};
    assign radicand = (div_q[M2_W-1:M2_W-4] != 4'd0) ? '1 : {div_q[M2_W-5:0], 4'd0};

    rmsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (count_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    rmsm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (radicand),
        .root     (root),
        .done     (sqrt_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            min_reg       <= SAMPLE_POS_MAX;
            max_reg       <= SAMPLE_NEG_MAX;
            full_reg      <= 1'b0;
            upd_reg       <= 1'b0;
            mbusy_reg     <= 1'b0;
            mdone_reg     <= 1'b0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mdone_reg <= 1'b0;
            if (cmd.accept)
            begin
                upd_reg <= 1'b0;
                if (req_type == REQ_CLEAR)
                begin
                    count_reg <= '0;
                    mean_reg  <= '0;
                    m2_reg    <= '0;
                    min_reg   <= SAMPLE_POS_MAX;
                    max_reg   <= SAMPLE_NEG_MAX;
                    full_reg  <= 1'b0;
                end
                else if (count_reg == COUNT_FULL)
                    full_reg <= 1'b1;
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    upd_reg   <= 1'b1;
                    if (x_in < min_reg)
                        min_reg <= x_in;
                    if (x_in > max_reg)
                        max_reg <= x_in;
                end
            end
            if (cmd.mean_upd)
                mean_reg <= mean_sum[MEAN_W-1:0];
            if (cmd.m2_acc)
                m2_reg <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
            if (cmd.mul_start)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end
            else if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
                if (mcnt_reg == MCNT_W'(DIFF_W - 1))
                begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg  <= x_in;
            d1_reg <= d1_in;
        end
        // shift-add multiply, one multiplier bit per cycle
        if (cmd.mul_start)
            p_reg <= {{DIFF_W{1'b0}}, d2_mag};
        else if (mbusy_reg)
            p_reg <= {mul_sum, p_reg[DIFF_W-1:1]};
        if (cmd.sd_zero)
            sd_reg <= '0;
        else if (sqrt_done)
            sd_reg <= (root[ROOT_W-1:SD_W] != '0) ? '1 : root[SD_W-1:0];
        if (cmd.out_load)
        begin
            count_out     <= count_reg;
            mean_out      <= mean_reg;
            stdev_out     <= cmd.sd_zero ? '0 : sd_reg;
            min_out       <= min_reg;
            max_out       <= max_reg;
            saturated_out <= full_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign st.upd        = upd_reg;
    assign st.div_done   = div_done;
    assign st.mul_done   = mdone_reg;
    assign st.sqrt_done  = sqrt_done;
    assign st.count_zero = (count_reg == '0);
    assign st.out_free   = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// ----- rtl/running_mean_stdev_minmax_top.sv -----
`default_nettype none

// Running count, mean (Q16.16), population standard deviation (8 fraction bits),
// minimum and maximum of a signed 16-bit sample stream, by Welford's method.
// Every transfer in (add sample or clear) yields one result transfer out with the
// statistics as they stand after it. Items are handled one at a time; how long
// an added sample takes is set by the single 64-step restoring divider, used
// once for the mean update and once for M2/count, plus the 33-step shift-add
// multiplier and the 32-step square root. The output register holds a finished
// result, so the next item is taken while it waits. The count saturates at
// 65535; later samples are ignored and flagged.
module running_mean_stdev_minmax_top
    import rmsm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // sample[15:0]
    input  wire logic [0:0]   s_axis_tuser,   // req_type[0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // count_out[15:0], mean_out[47:16],
                                              // stdev_out[71:48], min_out[87:72],
                                              // max_out[103:88]
    output logic [0:0]        m_axis_tuser    // saturated_out[0]
);

    cmd_t                cmd;
    status_t             st;
    logic [COUNT_W-1:0]  count_out;
    logic [MEAN_W-1:0]   mean_out;
    logic [SD_W-1:0]     stdev_out;
    logic [SAMPLE_W-1:0] min_out;
    logic [SAMPLE_W-1:0] max_out;
    logic                saturated_out;

    rmsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rmsm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .req_type      (s_axis_tuser[0]),
        .sample        (s_axis_tdata),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .count_out     (count_out),
        .mean_out      (mean_out),
        .stdev_out     (stdev_out),
        .min_out       (min_out),
        .max_out       (max_out),
        .saturated_out (saturated_out)
    );

    assign m_axis_tdata    = {max_out, min_out, stdev_out, mean_out, count_out};
    assign m_axis_tuser[0] = saturated_out;

endmodule

`default_nettype wire

// ----- rtl/rmsm_checker.sv -----
`default_nettype none

`include "running_mean_stdev_minmax_top_macros.svh"

module rmsm_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [15:0]  s_axis_tdata,
    input wire logic [0:0]   s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata,
    input wire logic [0:0]   m_axis_tuser
);

    logic in_xfer;
    logic empty_out;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign empty_out = m_axis_tvalid && (m_axis_tdata[15:0] == 16'd0);

    // one item at a time: no second transfer right after one
    `RMSM_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_xfer, !s_axis_tready, "ready after transfer")

    `RMSM_ASSERT_IMP(a_sat_full, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[15:0] == 16'hFFFF, "saturated flag without full count")

    `RMSM_ASSERT_IMP(a_empty_stats, clk, rst_n, empty_out,
        (m_axis_tdata[71:16] == 56'd0) && (m_axis_tdata[87:72] == 16'h7FFF) &&
        (m_axis_tdata[103:88] == 16'h8000), "empty statistics not at reset values")

    `RMSM_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind running_mean_stdev_minmax_top rmsm_checker u_rmsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- sim/running_mean_stdev_minmax_top_test.sv -----
`timescale 1ns / 1ps

module running_mean_stdev_minmax_top_test;
    import rmsm_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [15:0]        count;
        logic signed [31:0] mean;
        logic [23:0]        stdev;
        logic signed [15:0] min_v;
        logic signed [15:0] max_v;
        logic               sat;
    } stats_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    // predictor state
    longint unsigned     n_samples;
    longint              mean_acc;
    longint unsigned     m2_acc;
    logic signed [15:0]  low_seen;
    logic signed [15:0]  high_seen;
    logic                count_full;

    stats_t expected_stats[$];
    int     errors;
    int     items_sent;
    int     results_seen;
    int     cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     recv_hold;

    running_mean_stdev_minmax_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic void clear_stats();
        n_samples  = 0;
        mean_acc   = 0;
        m2_acc     = 0;
        low_seen   = SAMPLE_POS_MAX;
        high_seen  = SAMPLE_NEG_MAX;
        count_full = 1'b0;
    endfunction

    // Apply one request to the running statistics and return what the block reports.
    function automatic stats_t stats_update(logic req, logic signed [15:0] x);
        stats_t r;
        longint xs;
        longint d1;
        longint d2;
        logic [127:0] prod;
        longint unsigned term;
        longint unsigned q;
        longint unsigned sd;
        if (req == REQ_CLEAR)
            clear_stats();
        else if (n_samples >= 65535)
            count_full = 1'b1;
        else
        begin
            n_samples = n_samples + 1;
            xs = longint'(x) * 65536;
            d1 = xs - mean_acc;
            mean_acc = mean_acc + d1 / longint'(n_samples);
            d2 = xs - mean_acc;
            prod = (128'(magnitude(d1)) * 128'(magnitude(d2))) >> PROD_SHIFT;
            term = (prod[127:64] != 0) ? '1 : prod[63:0];
            m2_acc = (m2_acc > ~term) ? '1 : m2_acc + term;
            if (x < low_seen)
                low_seen = x;
            if (x > high_seen)
                high_seen = x;
        end
        sd = 0;
        if (n_samples != 0)
        begin
            q = m2_acc / n_samples;
            q = (q > (64'hFFFF_FFFF_FFFF_FFFF >> 4)) ? '1 : (q << 4);
            sd = int_sqrt(q);
            if (sd > 64'hFFFFFF)
                sd = 64'hFFFFFF;
        end
        r.count = n_samples[15:0];
        r.mean  = mean_acc[31:0];
        r.stdev = sd[23:0];
        r.min_v = low_seen;
        r.max_v = high_seen;
        r.sat   = count_full;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(logic req, logic [15:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = x;
        s_axis_tuser  = req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_stats.push_back(stats_update(req, x));
        items_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_stats.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(20)) - 10);
            2: return $urandom_range(1) ? 16'(SAMPLE_POS_MAX - $urandom_range(3))
                                        : 16'(SAMPLE_NEG_MAX + $urandom_range(3));
            3: return 16'($signed($urandom_range(2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] pts[12];
        pts = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555,
                16'hAAAA, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h1234};
        send_request(REQ_CLEAR, 16'hFFFF);
        send_request(REQ_SAMPLE, 16'h0000);
        send_request(REQ_CLEAR, 16'h0000);
        foreach (pts[i])
            send_request(REQ_SAMPLE, pts[i]);
        send_request(REQ_CLEAR, 16'h1234);
        send_request(REQ_SAMPLE, 16'h8000);
        send_request(REQ_SAMPLE, 16'h8000);
        send_request(REQ_CLEAR, 16'h0000);
        send_request(REQ_SAMPLE, 16'h7FFF);
        send_request(REQ_CLEAR, 16'h0000);
    endtask

    task automatic test_random(int num, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (num)
        begin
            if ($urandom_range(99) < 3)
                send_request(REQ_CLEAR, 16'($urandom));
            else
                send_request(REQ_SAMPLE, random_sample());
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Hold the result side off while the sender keeps offering items.
    task automatic test_backpressure();
        recv_hold = 3000;
        repeat (12)
            send_request(REQ_SAMPLE, random_sample());
    endtask

    // Pause the sender until every outstanding result is back.
    task automatic test_drain_pause();
        repeat (5)
            send_request(REQ_SAMPLE, random_sample());
        wait_drained();
        repeat (5)
            send_request(REQ_SAMPLE, random_sample());
    endtask

    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold--;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        stats_t got;
        stats_t exp_r;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_stats.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.count = m_axis_tdata[15:0];
            got.mean  = m_axis_tdata[47:16];
            got.stdev = m_axis_tdata[71:48];
            got.min_v = m_axis_tdata[87:72];
            got.max_v = m_axis_tdata[103:88];
            got.sat   = m_axis_tuser[0];
            results_seen++;
            if (expected_stats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, actual %h", $time, got);
            end
            else
            begin
                exp_r = expected_stats.pop_front();
                if (got.count !== exp_r.count)
                    $display("%0t: count expected %0d actual %0d", $time,
                             exp_r.count, got.count);
                if (got.mean !== exp_r.mean)
                    $display("%0t: mean expected %h actual %h", $time,
                             exp_r.mean, got.mean);
                if (got.stdev !== exp_r.stdev)
                    $display("%0t: stdev expected %h actual %h", $time,
                             exp_r.stdev, got.stdev);
                if (got.min_v !== exp_r.min_v)
                    $display("%0t: min expected %0d actual %0d", $time,
                             exp_r.min_v, got.min_v);
                if (got.max_v !== exp_r.max_v)
                    $display("%0t: max expected %0d actual %0d", $time,
                             exp_r.max_v, got.max_v);
                if (got.sat !== exp_r.sat)
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             exp_r.sat, got.sat);
                if (got !== exp_r)
                    errors++;
            end
        end
    end

    initial
    begin
        errors         = 0;
        items_sent     = 0;
        results_seen   = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        clear_stats();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(450, 0, 0);
        test_random(400, 83, 0);
        test_random(400, 0, 83);
        test_random(450, 18, 18);
        test_backpressure();
        test_drain_pause();

        wait_drained();
        repeat (300) @(negedge clk);
        $display("Sent %0d requests (samples and clears) and checked %0d results,",
                 items_sent, results_seen);
        $display("covering extreme samples, clears, idle gaps and long output stalls.");
        if (errors == 0 && expected_stats.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
